// ===== hw/rtl/text_mode_pixel_generator_top_assert.svh =====
// Assertion macros used by the text-mode pixel generator controller.
`ifndef TEXT_MODE_PIXEL_GENERATOR_TOP_ASSERT_SVH
`define TEXT_MODE_PIXEL_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, checked on clk and disabled while rst_n is low.
`define TMPG_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tmpg assertion failed");

// Next-cycle implication, checked on clk and disabled while rst_n is low.
`define TMPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tmpg assertion failed");

`endif

// ===== hw/rtl/tmpg_pkg.sv =====
// Shared constants, types and a helper function of the text-mode pixel generator.
package tmpg_pkg;

  localparam int TEXT_CELLS      = 16384;
  localparam int FONT_BYTES      = 2048;
  localparam int PALETTE_ENTRIES = 32;

  localparam int CELL_AW = $clog2(TEXT_CELLS);
  localparam int FONT_AW = $clog2(FONT_BYTES);
  localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);
  localparam int OFF_W   = 17;

  localparam int REQ_W    = 3;
  localparam int ADDR_W   = 14;
  localparam int WDATA_W  = 32;
  localparam int PIX_W    = 10;
  localparam int COLOR_W  = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_CHAR_WRITE    = 3'd0,
    REQ_ATTR_WRITE    = 3'd1,
    REQ_FONT_WRITE    = 3'd2,
    REQ_PALETTE_WRITE = 3'd3,
    REQ_FRAME_TICK    = 3'd4,
    REQ_PIXEL_QUERY   = 3'd5
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEXT_CONTROL  = 3'd0,
    CFG_BORDER_X      = 3'd1,
    CFG_BORDER_Y      = 3'd2,
    CFG_SCREEN_WIDTH  = 3'd3,
    CFG_SCREEN_HEIGHT = 3'd4,
    CFG_CURSOR_COLUMN = 3'd5,
    CFG_CURSOR_ROW    = 3'd6,
    CFG_CURSOR_GLYPH  = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [2:0]  text_control;
    logic [5:0]  border_x;
    logic [5:0]  border_y;
    logic [10:0] screen_width;
    logic [9:0]  screen_height;
    logic [6:0]  cursor_column;
    logic [6:0]  cursor_row;
    logic [15:0] cursor_glyph;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic mul;
    logic wrap_step;
    logic attr_load;
    logic glyph;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic off_ge;
  } sts_t;

  // Palette words keep the high nibbles of bytes 1, 2 and 3 as red, green, blue.
  function automatic logic [COLOR_W-1:0] pack_color(input logic [WDATA_W-1:0] w);
    return {w[15:12], w[23:20], w[31:28]};
  endfunction

endpackage

// ===== hw/rtl/tmpg_stream_if.sv =====
// Valid/ready channel interfaces for request items and pixel results.
interface tmpg_in_if;
  import tmpg_pkg::*;
  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [ADDR_W-1:0]  address;
  logic [WDATA_W-1:0] write_data;
  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;

  modport source(output valid, req_type, address, write_data, pixel_x, pixel_y,
                 input ready);
  modport sink(input valid, req_type, address, write_data, pixel_x, pixel_y,
               output ready);
endinterface

interface tmpg_out_if;
  import tmpg_pkg::*;
  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] pixel_color;
  logic               pixel_drawn;

  modport source(output valid, pixel_color, pixel_drawn, input ready);
  modport sink(input valid, pixel_color, pixel_drawn, output ready);
endinterface

// ===== hw/rtl/tmpg_cfg_regs.sv =====
// Configuration register file written through the plain write port.
module tmpg_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tmpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tmpg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tmpg_pkg::cfg_t                 cfg
);
  import tmpg_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_TEXT_CONTROL:  cfg_nxt.text_control  = cfg_wdata[2:0];
        CFG_BORDER_X:      cfg_nxt.border_x      = cfg_wdata[5:0];
        CFG_BORDER_Y:      cfg_nxt.border_y      = cfg_wdata[5:0];
        CFG_SCREEN_WIDTH:  cfg_nxt.screen_width  = cfg_wdata[10:0];
        CFG_SCREEN_HEIGHT: cfg_nxt.screen_height = cfg_wdata[9:0];
        CFG_CURSOR_COLUMN: cfg_nxt.cursor_column = cfg_wdata[6:0];
        CFG_CURSOR_ROW:    cfg_nxt.cursor_row    = cfg_wdata[6:0];
        CFG_CURSOR_GLYPH:  cfg_nxt.cursor_glyph  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.text_control  <= '0;
      cfg_r.border_x      <= '0;
      cfg_r.border_y      <= '0;
      cfg_r.screen_width  <= 11'd640;
      cfg_r.screen_height <= 10'd480;
      cfg_r.cursor_column <= '0;
      cfg_r.cursor_row    <= '0;
      cfg_r.cursor_glyph  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/tmpg_datapath.sv =====
// Datapath: item registers, text stores, window geometry and pixel lookup.
module tmpg_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tmpg_pkg::cfg_t                cfg,
  input  tmpg_pkg::cmd_t                cmd,
  input  logic [tmpg_pkg::REQ_W-1:0]    in_req_type,
  input  logic [tmpg_pkg::ADDR_W-1:0]   in_address,
  input  logic [tmpg_pkg::WDATA_W-1:0]  in_write_data,
  input  logic [tmpg_pkg::PIX_W-1:0]    in_pixel_x,
  input  logic [tmpg_pkg::PIX_W-1:0]    in_pixel_y,
  output logic [tmpg_pkg::COLOR_W-1:0]  out_pixel_color,
  output logic                          out_pixel_drawn,
  output tmpg_pkg::sts_t                sts
);
  import tmpg_pkg::*;

  logic [7:0]         char_mem [TEXT_CELLS];
  logic [7:0]         attr_mem [TEXT_CELLS];
  logic [7:0]         font_mem [FONT_BYTES];
  logic [COLOR_W-1:0] pal_mem  [PALETTE_ENTRIES];

  req_t               type_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [WDATA_W-1:0] wdata_r;
  logic [PIX_W-1:0]   px_r;
  logic [PIX_W-1:0]   py_r;
  logic [2:0]         blink_r;

  logic [10:0] colsx8_r;
  logic [9:0]  rowsx8_r;
  logic [9:0]  ox_r;
  logic [8:0]  oy_r;
  logic [7:0]  stride_r;

  logic [7:0]  cx_r;
  logic [6:0]  cy_r;
  logic [2:0]  xc_r;
  logic [2:0]  yc_r;
  logic        px_ok_r;
  logic        cursor_hit_r;
  logic [OFF_W-1:0] off_r;

  logic [7:0]         char_q_r;
  logic [7:0]         attr_q_r;
  logic [7:0]         attr_r;
  logic [7:0]         font_q_r;
  logic [COLOR_W-1:0] pal_q_r;
  logic               drawn_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_drawn_r;

  logic [11:0] inner_x;
  logic [10:0] inner_y;
  logic [11:0] rx;
  logic [11:0] ry;
  logic        inwin;
  logic [OFF_W-1:0] addr_ext;
  logic [OFF_W-1:0] off_nxt;
  logic [14:0] row_base;
  logic [7:0]  ch_sel;
  logic [7:0]  attr_sel;
  logic [FONT_AW-1:0] font_rd_addr;
  logic        glyph_bit;
  logic [PAL_AW-1:0] pal_rd_idx;
  logic        bg_clear;
  logic        char_we;
  logic        attr_we;
  logic        font_we;
  logic        pal_we;

  always_comb begin
    inner_x = {1'b0, cfg.screen_width} - {5'b0, cfg.border_x, 1'b0};
    inner_y = {1'b0, cfg.screen_height} - {4'b0, cfg.border_y, 1'b0};
  end

  // Window geometry is registered from the configuration and follows it in the next cycle.
  always_ff @(posedge clk) begin
    colsx8_r <= inner_x[11] ? 11'd0 : {inner_x[10:3], 3'b000};
    rowsx8_r <= inner_y[10] ? 10'd0 : {inner_y[9:3], 3'b000};
    ox_r     <= cfg.screen_width[10:1]
                - (inner_x[11] ? 10'd0 : {1'b0, inner_x[10:3], 1'b0} << 1);
    oy_r     <= cfg.screen_height[9:1]
                - (inner_y[10] ? 9'd0 : {1'b0, inner_y[9:3], 1'b0} << 1);
    stride_r <= cfg.screen_width[10:3];
  end

  always_comb begin
    rx    = {2'b00, px_r} - {2'b00, ox_r};
    ry    = {2'b00, py_r} - {3'b000, oy_r};
    inwin = !rx[11] && (rx[10:0] < colsx8_r) && !ry[11] && (ry[10:0] < {1'b0, rowsx8_r});
    addr_ext = OFF_W'(addr_r);
    row_base = 15'(cy_r) * 15'(stride_r);
    off_nxt  = OFF_W'(cx_r) + OFF_W'(row_base);
    ch_sel   = cursor_hit_r ? cfg.cursor_glyph[15:8] : char_q_r;
    attr_sel = cursor_hit_r ? cfg.cursor_glyph[7:0] : attr_q_r;
    font_rd_addr = FONT_AW'({ch_sel, yc_r});
    glyph_bit  = font_q_r[3'd7 - xc_r];
    pal_rd_idx = glyph_bit ? {1'b0, attr_r[7:4]} : {1'b1, attr_r[3:0]};
    bg_clear   = cfg.text_control[1] && (attr_r[3:0] == 4'd0);
    char_we = cmd.exec && (type_r == REQ_CHAR_WRITE) && (addr_ext < OFF_W'(TEXT_CELLS));
    attr_we = cmd.exec && (type_r == REQ_ATTR_WRITE) && (addr_ext < OFF_W'(TEXT_CELLS));
    font_we = cmd.exec && (type_r == REQ_FONT_WRITE) && (addr_ext < OFF_W'(FONT_BYTES));
    pal_we  = cmd.exec && (type_r == REQ_PALETTE_WRITE)
              && (addr_ext < OFF_W'(PALETTE_ENTRIES));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      type_r  <= req_t'(in_req_type);
      addr_r  <= in_address;
      wdata_r <= in_write_data;
      px_r    <= in_pixel_x;
      py_r    <= in_pixel_y;
    end
    if (cmd.exec) begin
      cx_r    <= rx[10:3];
      xc_r    <= rx[2:0];
      cy_r    <= ry[9:3];
      yc_r    <= ry[2:0];
      px_ok_r <= cfg.text_control[0] && inwin;
      drawn_r <= 1'b0;
    end
    if (cmd.mul) begin
      off_r        <= off_nxt;
      cursor_hit_r <= cfg.text_control[2] && !blink_r[2]
                      && (cx_r == {1'b0, cfg.cursor_column}) && (cy_r == cfg.cursor_row);
    end
    if (cmd.wrap_step) begin
      off_r <= off_r - OFF_W'(TEXT_CELLS);
    end
    if (cmd.attr_load) begin
      attr_r <= attr_sel;
    end
    if (cmd.glyph) begin
      drawn_r <= px_ok_r && (glyph_bit || !bg_clear);
    end
    if (cmd.load_out) begin
      out_color_r <= drawn_r ? pal_q_r : '0;
      out_drawn_r <= drawn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_r <= '0;
    end else if (cmd.exec && (type_r == REQ_FRAME_TICK)) begin
      blink_r <= blink_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (char_we) begin
      char_mem[addr_ext[CELL_AW-1:0]] <= wdata_r[7:0];
    end
    char_q_r <= char_mem[off_r[CELL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (attr_we) begin
      attr_mem[addr_ext[CELL_AW-1:0]] <= wdata_r[7:0];
    end
    attr_q_r <= attr_mem[off_r[CELL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (font_we) begin
      font_mem[addr_ext[FONT_AW-1:0]] <= wdata_r[7:0];
    end
    font_q_r <= font_mem[font_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[addr_r[PAL_AW-1:0]] <= pack_color(wdata_r);
    end
    pal_q_r <= pal_mem[pal_rd_idx];
  end

  assign sts.is_query = (type_r == REQ_PIXEL_QUERY);
  assign sts.off_ge   = (off_r >= OFF_W'(TEXT_CELLS));

  assign out_pixel_color = out_color_r;
  assign out_pixel_drawn = out_drawn_r;

endmodule

// ===== hw/rtl/tmpg_controller.sv =====
// Controller: sequences one item through the datapath and owns the handshakes.
`include "text_mode_pixel_generator_top_assert.svh"

module tmpg_controller (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  tmpg_pkg::sts_t sts,
  output tmpg_pkg::cmd_t cmd
);
  import tmpg_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_EXEC  = 7'b0000010,
    S_MUL   = 7'b0000100,
    S_WRAP  = 7'b0001000,
    S_CELL  = 7'b0010000,
    S_GLYPH = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = in_valid;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.is_query ? S_MUL : S_DONE;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        cmd.wrap_step = sts.off_ge;
        if (!sts.off_ge) begin
          state_nxt = S_CELL;
        end
      end
      S_CELL: begin
        cmd.attr_load = 1'b1;
        state_nxt     = S_GLYPH;
      end
      S_GLYPH: begin
        cmd.glyph = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        cmd.load_out = out_free;
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `TMPG_ASSERT_NEXT(a_accept_starts_exec, in_valid && in_ready, state_r == S_EXEC)
  `TMPG_ASSERT_NEXT(a_done_holds, state_r == S_DONE && !out_free, state_r == S_DONE && out_valid_r)
  `TMPG_ASSERT_NEXT(a_wrap_exits_in_range, state_r == S_WRAP && !sts.off_ge, state_r == S_CELL)
  `TMPG_ASSERT_SAME(a_load_needs_free_slot, cmd.load_out, !out_valid_r || out_ready)

endmodule

// ===== hw/rtl/text_mode_pixel_generator_top.sv =====
// Top level of the text-mode pixel generator: config registers, controller, datapath.
//
//   Port group   Direction  Carries
//   in_chan      sink       request items: store writes, frame ticks, pixel queries
//   out_chan     source     one result per item: pixel color and drawn flag
//   cfg_*        write      register index and data, no read-back
//
// A write or frame tick passes the exec and done states; items transfer only in idle.
// A pixel query passes exec, mul, wrap, cell, glyph and done, set by the chain of
// dependent cell, font and palette reads; at most one offset wrap subtraction is needed.
// Reset is synchronous and clears control state, config registers and the blink counter only.
// The stores need no clearing pass and hold whatever was last written.
// A finished result waits in the output register; the next item transfers meanwhile.
module text_mode_pixel_generator_top (
  input  logic                            clk,
  input  logic                            rst_n,
  tmpg_in_if.sink                         in_chan,
  tmpg_out_if.source                      out_chan,
  input  logic                            cfg_we,
  input  logic [tmpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmpg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tmpg_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  tmpg_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tmpg_controller u_controller (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tmpg_datapath u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .cmd             (cmd),
    .in_req_type     (in_chan.req_type),
    .in_address      (in_chan.address),
    .in_write_data   (in_chan.write_data),
    .in_pixel_x      (in_chan.pixel_x),
    .in_pixel_y      (in_chan.pixel_y),
    .out_pixel_color (out_chan.pixel_color),
    .out_pixel_drawn (out_chan.pixel_drawn),
    .sts             (sts)
  );

endmodule
